// ----- hdl/spmc_pkg.sv -----
// Package for the sorted pixel merge/clip block: transaction types,
// request and register codes, control/status structs.
// No dependencies.
package spmc_pkg;

  // Default list capacity
  localparam int LIST_DEPTH_DEF = 512;

  // Coordinate and color widths
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int CLIP_W  = 15;

  // List entry widths: erase holds (x,y), draw holds (x,y,color)
  localparam int ERASE_W = 2 * COORD_W;
  localparam int DRAW_W  = 2 * COORD_W + COLOR_W;

  // Request codes
  localparam logic [1:0] REQ_LOAD_ERASE = 2'd0;
  localparam logic [1:0] REQ_LOAD_DRAW  = 2'd1;
  localparam logic [1:0] REQ_PULL       = 2'd2;

  // Configuration register indexes
  localparam logic REG_CLIP_X = 1'b0;
  localparam logic REG_CLIP_Y = 1'b1;

  // Configuration reset values
  localparam logic [CLIP_W-1:0] CLIP_X_RST = 15'd240;
  localparam logic [CLIP_W-1:0] CLIP_Y_RST = 15'd320;

  // Input transaction
  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [COLOR_W-1:0]        color;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic                      pix_valid;
    logic signed [COORD_W-1:0] pix_x;
    logic signed [COORD_W-1:0] pix_y;
    logic [COLOR_W-1:0]        pix_color;
    logic                      merge_done;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_erase;  // append input to erase list
    logic load_draw;   // append input to draw list
    logic pick;        // advance the read pointer of the selected head
    logic emit_pix;    // register selected head as a pixel write
    logic emit_done;   // register done result, clear all counters
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exhausted;   // both lists fully read
    logic visible;     // selected head lies inside the clip box
  } sts_t;

endpackage

// ----- hdl/sorted_pixel_merge_clip.sv -----
// Top level of the sorted pixel merge/clip block: controller plus datapath.
// Depends on spmc_pkg, spmc_ctrl, spmc_dp (and spmc_ram below it).
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high
//   and busy low. req_type load-erase / load-draw appends (x,y[,color]) to
//   the erase or draw list (ignored when that list holds LIST_DEPTH
//   entries); these keep busy low and give no result.
//   req_type pull merges both lists by ascending y (ties to erase), skips
//   entries outside [0..clip_max_x] x [0..clip_max_y] and gives one result.
//   Result channel: out_strobe is high for one cycle with out_data; there is
//   no backpressure. A pixel write carries pix_valid=1 (color 0 for erase);
//   a done result carries merge_done=1 and clears all list counters.
//   Pull: it goes to EVAL with the list heads on the RAM outputs; each
//   clipped entry skipped adds a pass through FETCH for the registered
//   RAM read of the advanced pointer. The result is registered; busy is
//   high from the accept to the result cycle, where the next pull can start.
//   Config: cfg_we writes clip_max_x (index 0) or clip_max_y (index 1).
//   Reset: counters cleared, clip box 240 x 320, list RAMs not cleared.
module sorted_pixel_merge_clip
  import spmc_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_strobe,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [CLIP_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  spmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  spmc_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ----- hdl/spmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/spmc_ctrl.sv -----
// Controller FSM for the sorted pixel merge/clip block.
// Depends on spmc_pkg (cmd_t, sts_t, request codes).
module spmc_ctrl
  import spmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  sts_t       sts,
  output logic       busy,
  output cmd_t       cmd
);

  // State codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (req_type)
            REQ_LOAD_ERASE: cmd.load_erase = 1'b1;
            REQ_LOAD_DRAW:  cmd.load_draw  = 1'b1;
            REQ_PULL:       state_nxt      = ST_EVAL;
            default:        ;
          endcase
        end
      end
      ST_EVAL: begin
        // heads are on the RAM outputs here
        if (sts.exhausted) begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.pick = 1'b1;
          if (sts.visible) begin
            cmd.emit_pix = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        // the RAMs read the advanced pointer in this state
        state_nxt = ST_EVAL;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/spmc_dp.sv -----
// Datapath for the sorted pixel merge/clip block: list RAMs, counters,
// head selection, clip test, clip registers and result register.
// Depends on spmc_pkg and spmc_ram.
module spmc_dp
  import spmc_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_t               in_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [CLIP_W-1:0] cfg_wdata,
  output logic              out_strobe,
  output out_t              out_data
);

  localparam int AW    = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  logic [CNT_W-1:0] erase_cnt_r, erase_cnt_nxt;
  logic [CNT_W-1:0] draw_cnt_r,  draw_cnt_nxt;
  logic [CNT_W-1:0] erase_rd_r,  erase_rd_nxt;
  logic [CNT_W-1:0] draw_rd_r,   draw_rd_nxt;
  logic [CLIP_W-1:0] clip_x_r, clip_y_r;
  logic              out_strobe_r;
  out_t              out_data_r, out_data_nxt;

  logic               erase_we, draw_we;
  logic [ERASE_W-1:0] erase_q;
  logic [DRAW_W-1:0]  draw_q;

  logic                      e_left, d_left, take_erase;
  logic signed [COORD_W-1:0] e_x, e_y, d_x, d_y, sel_x, sel_y;
  logic [COLOR_W-1:0]        d_c, sel_c;

  // List memories, read at the current pointers every cycle
  assign erase_we = cmd.load_erase && (erase_cnt_r != FULL);
  assign draw_we  = cmd.load_draw  && (draw_cnt_r  != FULL);

  spmc_ram #(.WIDTH(ERASE_W), .DEPTH(LIST_DEPTH)) u_erase_ram (
    .clk   (clk),
    .we    (erase_we),
    .waddr (erase_cnt_r[AW-1:0]),
    .wdata ({in_data.pos_x, in_data.pos_y}),
    .raddr (erase_rd_r[AW-1:0]),
    .rdata (erase_q)
  );

  spmc_ram #(.WIDTH(DRAW_W), .DEPTH(LIST_DEPTH)) u_draw_ram (
    .clk   (clk),
    .we    (draw_we),
    .waddr (draw_cnt_r[AW-1:0]),
    .wdata ({in_data.pos_x, in_data.pos_y, in_data.color}),
    .raddr (draw_rd_r[AW-1:0]),
    .rdata (draw_q)
  );

  // Head selection: ties go to the erase list
  assign {e_x, e_y}      = erase_q;
  assign {d_x, d_y, d_c} = draw_q;
  assign e_left     = erase_rd_r < erase_cnt_r;
  assign d_left     = draw_rd_r  < draw_cnt_r;
  assign take_erase = e_left && (!d_left || (e_y <= d_y));
  assign sel_x      = take_erase ? e_x : d_x;
  assign sel_y      = take_erase ? e_y : d_y;
  assign sel_c      = take_erase ? '0  : d_c;

  // Clip test against [0..max] in both axes
  assign sts.exhausted = !e_left && !d_left;
  assign sts.visible   = !sel_x[COORD_W-1] && !sel_y[COORD_W-1] &&
                         (sel_x[CLIP_W-1:0] <= clip_x_r) &&
                         (sel_y[CLIP_W-1:0] <= clip_y_r);

  // Counter updates
  always_comb begin
    erase_cnt_nxt = erase_cnt_r;
    draw_cnt_nxt  = draw_cnt_r;
    erase_rd_nxt  = erase_rd_r;
    draw_rd_nxt   = draw_rd_r;
    if (erase_we) begin
      erase_cnt_nxt = erase_cnt_r + 1'b1;
    end
    if (draw_we) begin
      draw_cnt_nxt = draw_cnt_r + 1'b1;
    end
    if (cmd.pick) begin
      if (take_erase) begin
        erase_rd_nxt = erase_rd_r + 1'b1;
      end else begin
        draw_rd_nxt = draw_rd_r + 1'b1;
      end
    end
    if (cmd.emit_done) begin
      erase_cnt_nxt = '0;
      draw_cnt_nxt  = '0;
      erase_rd_nxt  = '0;
      draw_rd_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_cnt_r <= '0;
      draw_cnt_r  <= '0;
      erase_rd_r  <= '0;
      draw_rd_r   <= '0;
    end else begin
      erase_cnt_r <= erase_cnt_nxt;
      draw_cnt_r  <= draw_cnt_nxt;
      erase_rd_r  <= erase_rd_nxt;
      draw_rd_r   <= draw_rd_nxt;
    end
  end

  // Clip box registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_x_r <= CLIP_X_RST;
      clip_y_r <= CLIP_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CLIP_X: clip_x_r <= cfg_wdata;
        REG_CLIP_Y: clip_y_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Result register
  always_comb begin
    out_data_nxt = '0;
    if (cmd.emit_pix) begin
      out_data_nxt.pix_valid = 1'b1;
      out_data_nxt.pix_x     = sel_x;
      out_data_nxt.pix_y     = sel_y;
      out_data_nxt.pix_color = sel_c;
    end else begin
      out_data_nxt.merge_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_pix || cmd.emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pix || cmd.emit_done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- hdl/spmc_checker.sv -----
// Port-level checker for sorted_pixel_merge_clip, attached by bind.
// Depends on spmc_pkg.
module spmc_checker
  import spmc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input in_t               in_data,
  input logic              out_strobe,
  input out_t              out_data,
  input logic              cfg_we,
  input logic              cfg_idx,
  input logic [CLIP_W-1:0] cfg_wdata
);

  // A pull transaction makes the block busy
  a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.req_type == REQ_PULL) |=> busy)
    else $error("pull accepted but busy not raised");

  // A result only follows a busy cycle, and the block is free again with it
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) && !busy)
    else $error("result outside a pull");

  // A result is either a pixel write or done, never both or neither
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.pix_valid != out_data.merge_done))
    else $error("result is neither pixel nor done");

  // A done result carries zero payload
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.merge_done |->
      (out_data.pix_x == '0) && (out_data.pix_y == '0) && (out_data.pix_color == '0))
    else $error("done result with nonzero payload");

  // Pixel writes are never at negative coordinates
  a_pix_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.pix_valid |->
      !out_data.pix_x[COORD_W-1] && !out_data.pix_y[COORD_W-1])
    else $error("pixel write outside clip box");

endmodule

bind sorted_pixel_merge_clip spmc_checker u_spmc_checker (.*);
